### rtl/lspg_pkg.sv
// Shared constants, types and tap table for the LFSR pattern sequence generator.
`timescale 1ns / 1ps
`default_nettype none

package lspg_pkg;

	// Depth range and field widths
	localparam int MAX_DEPTH = 12;
	localparam int MIN_DEPTH = 4;
	localparam int DEPTH_W   = 4;
	localparam int STATE_W   = 12;
	localparam int INDEX_W   = 13;
	localparam int PHASE_W   = 2;

	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [STATE_W-1:0] shift_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [PHASE_W-1:0] phase_t;

	// Position inside a triplet
	localparam phase_t PH_HEAD = 2'd0;
	localparam phase_t PH_MID  = 2'd1;
	localparam phase_t PH_TAIL = 2'd2;

	localparam depth_t DEPTH_RESET = 4'd4;

	// Pattern position and LFSR state
	typedef struct packed {
		shift_t shift;
		index_t index;
		phase_t phase;
		logic   first_pending;
	} lspg_state_t;

	localparam lspg_state_t STATE_START = '{
		shift:         '1,
		index:         '0,
		phase:         PH_HEAD,
		first_pending: 1'b1
	};

	// Feedback taps for each depth (low d bits of the shift register)
	function automatic shift_t tap_mask(input depth_t d);
		shift_t m;
		case (d)
			4'd4:    m = 12'h009;
			4'd5:    m = 12'h012;
			4'd6:    m = 12'h021;
			4'd7:    m = 12'h044;
			4'd8:    m = 12'h0C3;
			4'd9:    m = 12'h108;
			4'd10:   m = 12'h240;
			4'd11:   m = 12'h402;
			4'd12:   m = 12'h883;
			default: m = 12'h000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/lspg_if.sv
// Handshake channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface lspg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface lspg_rsp_if;
	logic valid;
	logic ready;
	logic symbol;
	logic last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface lspg_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] code_depth;

	modport source (output valid, output code_depth, input ready);
	modport sink   (input valid, input code_depth, output ready);
endinterface

`default_nettype wire

### rtl/lspg_step.sv
// Next-state and symbol logic for one pattern position.
`timescale 1ns / 1ps
`default_nettype none

module lspg_step (
	input  var lspg_pkg::lspg_state_t cur,
	input  var lspg_pkg::depth_t      code_depth,
	input  wire logic                 restart,
	output var lspg_pkg::lspg_state_t nxt,
	output logic                      symbol,
	output logic                      last
);
	import lspg_pkg::*;

	depth_t      d;
	shift_t      dmask;
	index_t      total;
	index_t      final_idx;
	index_t      idx;
	phase_t      phase;
	lspg_state_t st;
	shift_t      s;
	logic        fb;
	logic        in_code;

	// Clamp depth to the supported range
	always_comb begin
		if (code_depth < depth_t'(MIN_DEPTH)) begin
			d = depth_t'(MIN_DEPTH);
		end else if (code_depth > depth_t'(MAX_DEPTH)) begin
			d = depth_t'(MAX_DEPTH);
		end else begin
			d = code_depth;
		end
	end

	// Triplet count 2^d + d - 2 and mask of the active LFSR bits
	assign dmask     = shift_t'((index_t'(1) << d) - index_t'(1));
	assign total     = (index_t'(1) << d) + index_t'(d) - index_t'(2);
	assign final_idx = total - index_t'(1);

	// Restart takes effect before the symbol is formed
	assign st = restart ? STATE_START : cur;

	always_comb begin
		phase = (st.phase == 2'd3) ? PH_TAIL : st.phase;
		idx   = (st.index > final_idx) ? final_idx : st.index;
	end

	assign s       = st.shift & dmask;
	assign fb      = ^(s & tap_mask(d));
	assign in_code = (phase == PH_MID) && (idx >= index_t'(d - depth_t'(1)))
		&& (idx < final_idx);

	always_comb begin
		nxt    = st;
		symbol = 1'b1;
		last   = 1'b0;

		// Middle symbol of a code triplet
		if (in_code) begin
			if (st.first_pending) begin
				nxt.first_pending = 1'b0;
			end else begin
				symbol    = fb;
				nxt.shift = ((s << 1) & dmask) | shift_t'(fb);
			end
		end

		// Advance position
		if (phase == PH_TAIL) begin
			if (idx == final_idx) begin
				last = 1'b1;
				nxt  = STATE_START;
			end else begin
				nxt.phase = PH_HEAD;
				nxt.index = idx + index_t'(1);
			end
		end else begin
			nxt.phase = phase + phase_t'(1);
			nxt.index = idx;
		end
	end

endmodule

`default_nettype wire

### rtl/lfsr_pattern_sequence_generator_top.sv
// Top level of the LFSR pattern sequence generator.
//
// Usage:
//   req : one transaction per symbol wanted; restart = 1 rewinds the
//         pattern to its first symbol before that symbol is produced.
//   rsp : one transaction per accepted request, carrying symbol and last;
//         last marks the final symbol of a pattern of 3*(2^d + d - 2)
//         symbols, after which the pattern starts over.
//   cfg : writes code_depth (4..12, clamped outside) and rewinds the
//         pattern. Write only while no response is outstanding.
// Timing: the response is registered and valid in the cycle after the request is accepted.
// Throughput: one symbol per cycle while rsp.ready stays high; the LFSR feedback and position update
//   fit between the state registers and the response register.
// Stall: req.ready stays high while the response register is empty or
//   being drained; when rsp.ready is low with a response held, req.ready
//   drops and the response holds steady.
// Reset: depth returns to 4, the LFSR to all ones, position to the first
//   symbol, and the response register empties.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_pattern_sequence_generator_top (
	input  wire logic clk,
	input  wire logic arst_n,
	lspg_req_if.sink  req,
	lspg_rsp_if.source rsp,
	lspg_cfg_if.sink  cfg
);
	import lspg_pkg::*;

	depth_t      code_depth_q;
	lspg_state_t state_q;
	lspg_state_t state_nxt;
	logic        rsp_valid_q;
	logic        symbol_q;
	logic        last_q;
	logic        sym_nxt;
	logic        last_nxt;
	logic        req_fire;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	lspg_step u_step (
		.cur        (state_q),
		.code_depth (code_depth_q),
		.restart    (req.restart),
		.nxt        (state_nxt),
		.symbol     (sym_nxt),
		.last       (last_nxt)
	);

	// Depth register and pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_depth_q <= DEPTH_RESET;
			state_q      <= STATE_START;
		end else if (cfg.valid) begin
			code_depth_q <= cfg.code_depth;
			state_q      <= STATE_START;
		end else if (req_fire) begin
			state_q <= state_nxt;
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			symbol_q <= sym_nxt;
			last_q   <= last_nxt;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.symbol = symbol_q;
	assign rsp.last   = last_q;

endmodule

`default_nettype wire
